/* hdl/daily_bucket_window_counter_unit_macros.svh */
// Assertion macros used by the checker of the daily bucket window counter.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef DAILY_BUCKET_WINDOW_COUNTER_UNIT_MACROS_SVH
`define DAILY_BUCKET_WINDOW_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, off during reset
`define DBWC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("daily bucket window counter check failed");

// Next-cycle implication, off during reset
`define DBWC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("daily bucket window counter check failed");

`endif

/* hdl/dbwc_pkg.sv */
// Package of the daily bucket window counter: widths, operation codes,
// the datapath command struct and the window length saturation function.
// No dependencies.
package dbwc_pkg;

    localparam int DAYS_MAX = 64;
    localparam int SLOT_W   = $clog2(DAYS_MAX);
    localparam int HELD_W   = 7;
    localparam int DAY_W    = 20;
    localparam int CNT_W    = 32;
    localparam int SUM_W    = 64;
    localparam int OP_W     = 2;
    localparam int SDAY_W   = DAY_W + 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [HELD_W-1:0] WINDOW_RESET = 7'd7;
    // Word index of the window length register
    localparam logic REG_WINDOW = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_RANGE  = 2'd1,
        OP_WINDOW = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Command from the sequencer to the bucket datapath
    typedef struct packed {
        logic              start;
        logic              wr_en;
        logic              wr_zero;
        logic              add_count;
        logic              acc_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [SLOT_W-1:0] rd_addr;
    } t_dp_cmd;

    // Saturate the window length to 1..DAYS_MAX
    function automatic logic [HELD_W-1:0] eff_len(input logic [HELD_W-1:0] win);
        logic [HELD_W-1:0] n;
        n = win;
        if (n == '0) begin
            n = HELD_W'(1);
        end
        if (n > HELD_W'(DAYS_MAX)) begin
            n = HELD_W'(DAYS_MAX);
        end
        return n;
    endfunction

endpackage

/* hdl/dbwc_in_if.sv */
// Input channel of the daily bucket window counter: valid/ready and one item.
// Depends on dbwc_pkg.
interface dbwc_in_if;
    logic                          valid;
    logic                          ready;
    logic [dbwc_pkg::OP_W-1:0]     operation;
    logic [dbwc_pkg::DAY_W-1:0]    today_day;
    logic [dbwc_pkg::CNT_W-1:0]    count;
    logic [dbwc_pkg::DAY_W-1:0]    range_start_day;
    logic [dbwc_pkg::DAY_W-1:0]    range_end_day;

    modport source (
        output valid, operation, today_day, count, range_start_day, range_end_day,
        input  ready
    );
    modport sink (
        input  valid, operation, today_day, count, range_start_day, range_end_day,
        output ready
    );
endinterface

/* hdl/dbwc_out_if.sv */
// Result channel of the daily bucket window counter: valid/ready and one item.
// Depends on dbwc_pkg.
interface dbwc_out_if;
    logic                          valid;
    logic                          ready;
    logic [dbwc_pkg::SUM_W-1:0]    total;
    logic [dbwc_pkg::HELD_W-1:0]   buckets_held;

    modport source (
        output valid, total, buckets_held,
        input  ready
    );
    modport sink (
        input  valid, total, buckets_held,
        output ready
    );
endinterface

/* hdl/dbwc_dp.sv */
// Bucket datapath: the bucket memory, the shared 64-bit adder and the
// accumulator. Driven by the sequencer through dbwc_pkg::t_dp_cmd.
module dbwc_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dbwc_pkg::t_dp_cmd            i_cmd,
    input  logic [dbwc_pkg::CNT_W-1:0]   i_count,
    output logic [dbwc_pkg::SUM_W-1:0]   o_total
);

    localparam int SW = dbwc_pkg::SUM_W;
    localparam int CW = dbwc_pkg::CNT_W;

    logic [SW-1:0] r_mem [dbwc_pkg::DAYS_MAX];
    logic [SW-1:0] r_rdata;
    logic [SW-1:0] r_acc;
    logic [CW-1:0] r_count;
    logic          r_acc_en;
    logic [SW-1:0] sum;
    logic [SW-1:0] wdata;

    // Shared adder: bucket plus count for an add, bucket plus total for a query
    assign sum   = r_rdata + (i_cmd.add_count ? {{(SW-CW){1'b0}}, r_count} : r_acc);
    assign wdata = i_cmd.wr_zero ? '0 : sum;

    // Bucket memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= wdata;
        end
        r_rdata <= r_mem[i_cmd.rd_addr];
    end

    // Delay the in-range flag to line up with the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.acc_en;
        end
    end

    // Hold the count, clear and advance the running total
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc   <= '0;
            r_count <= i_count;
        end else if (r_acc_en) begin
            r_acc <= sum;
        end
    end

    assign o_total = r_acc;

endmodule

/* hdl/dbwc_ctrl.sv */
// Sequencer of the daily bucket window counter: ring state (newest day,
// newest slot, buckets held) and the per-item step sequence. Uses dbwc_pkg.
module dbwc_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dbwc_pkg::OP_W-1:0]     i_op,
    input  logic [dbwc_pkg::DAY_W-1:0]    i_today,
    input  logic [dbwc_pkg::DAY_W-1:0]    i_range_start,
    input  logic [dbwc_pkg::DAY_W-1:0]    i_range_end,
    input  logic [dbwc_pkg::HELD_W-1:0]   i_window,
    input  logic                          i_out_free,
    output logic                          o_ready,
    output logic                          o_done,
    output logic [dbwc_pkg::HELD_W-1:0]   o_held,
    output dbwc_pkg::t_dp_cmd             o_cmd
);

    localparam int HW = dbwc_pkg::HELD_W;
    localparam int DW = dbwc_pkg::DAY_W;
    localparam int SW = dbwc_pkg::SLOT_W;
    localparam int XW = dbwc_pkg::SDAY_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PLAN  = 8'b0000_0010,
        S_ZERO  = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_WR    = 8'b0001_0000,
        S_SUM   = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state                r_state, n_state;
    dbwc_pkg::t_op         r_op, n_op;
    logic [DW-1:0]         r_today, n_today;
    logic signed [XW-1:0]  r_lo, n_lo;
    logic signed [XW-1:0]  r_hi, n_hi;
    logic [DW-1:0]         r_day, n_day;
    logic [SW-1:0]         r_slot, n_slot;
    logic [HW-1:0]         r_held, n_held;
    logic [HW-1:0]         r_idx, n_idx;
    logic [SW-1:0]         r_waddr, n_waddr;
    logic [HW-1:0]         r_left, n_left;

    logic [HW-1:0]         cap;
    logic [DW-1:0]         gap;
    logic                  ahead;
    logic                  big;
    logic [HW:0]           held_sum;
    logic signed [XW-1:0]  age_day;

    assign cap      = dbwc_pkg::eff_len(i_window);
    assign ahead    = r_today > r_day;
    assign gap      = r_today - r_day;
    assign big      = gap >= DW'(cap);
    assign held_sum = {1'b0, r_held} + gap[HW:0];
    assign age_day  = $signed({2'b00, r_day}) - $signed({{(XW-HW){1'b0}}, r_idx});

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_today = r_today;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_day   = r_day;
        n_slot  = r_slot;
        n_held  = r_held;
        n_idx   = r_idx;
        n_waddr = r_waddr;
        n_left  = r_left;
        o_ready = 1'b0;
        o_done  = 1'b0;
        o_cmd   = '0;
        o_cmd.rd_addr = r_slot;
        o_cmd.wr_addr = r_slot;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    o_cmd.start = 1'b1;
                    n_op    = dbwc_pkg::t_op'(i_op);
                    n_today = i_today;
                    if (dbwc_pkg::t_op'(i_op) == dbwc_pkg::OP_WINDOW) begin
                        n_lo = $signed({2'b00, i_today}) - $signed(XW'(cap))
                               + $signed(XW'(1));
                        n_hi = $signed({2'b00, i_today});
                    end else begin
                        n_lo = $signed({2'b00, i_range_start});
                        n_hi = $signed({2'b00, i_range_end});
                    end
                    n_state = S_PLAN;
                end
            end

            // Decide the ring update, the query walk or the clear
            S_PLAN: begin
                n_idx = '0;
                case (r_op)
                    dbwc_pkg::OP_ADD: begin
                        if (r_held == '0) begin
                            n_slot  = '0;
                            n_day   = r_today;
                            n_held  = HW'(1);
                            n_waddr = '0;
                            n_left  = HW'(1);
                            n_state = S_ZERO;
                        end else if (!ahead) begin
                            n_state = S_RD;
                        end else if (big) begin
                            n_day   = r_today;
                            n_held  = cap;
                            n_waddr = '0;
                            n_left  = HW'(dbwc_pkg::DAYS_MAX);
                            n_state = S_ZERO;
                        end else begin
                            n_day   = r_today;
                            n_slot  = r_slot + gap[SW-1:0];
                            n_waddr = r_slot + SW'(1);
                            n_left  = gap[HW-1:0];
                            n_held  = (held_sum > {1'b0, cap}) ? cap : held_sum[HW-1:0];
                            n_state = S_ZERO;
                        end
                    end
                    dbwc_pkg::OP_RANGE, dbwc_pkg::OP_WINDOW: begin
                        n_state = (r_held == '0) ? S_DONE : S_SUM;
                    end
                    default: begin
                        n_held  = '0;
                        n_day   = '0;
                        n_slot  = '0;
                        n_state = S_DONE;
                    end
                endcase
            end

            // Zero one fresh bucket a cycle
            S_ZERO: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_zero = 1'b1;
                o_cmd.wr_addr = r_waddr;
                n_waddr = r_waddr + SW'(1);
                n_left  = r_left - HW'(1);
                if (r_left == HW'(1)) begin
                    n_state = S_RD;
                end
            end

            // Read the newest bucket
            S_RD: begin
                n_state = S_WR;
            end

            // Write back the newest bucket plus the count
            S_WR: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.add_count = 1'b1;
                n_state = S_DONE;
            end

            // Walk buckets from newest to oldest, flag those in range
            S_SUM: begin
                o_cmd.rd_addr = r_slot - r_idx[SW-1:0];
                o_cmd.acc_en  = (age_day >= r_lo) && (age_day <= r_hi);
                n_idx = r_idx + HW'(1);
                if (n_idx == r_held) begin
                    n_state = S_DRAIN;
                end
            end

            // Let the last read reach the accumulator
            S_DRAIN: begin
                n_state = S_DONE;
            end

            // Hand the result to the output register when it is free
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_day   <= '0;
            r_slot  <= '0;
            r_held  <= '0;
            r_idx   <= '0;
            r_left  <= '0;
            r_waddr <= '0;
        end else begin
            r_state <= n_state;
            r_day   <= n_day;
            r_slot  <= n_slot;
            r_held  <= n_held;
            r_idx   <= n_idx;
            r_left  <= n_left;
            r_waddr <= n_waddr;
        end
    end

    // Item fields held for the duration of the work
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_today <= n_today;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
    end

    assign o_held = r_held;

endmodule

/* hdl/daily_bucket_window_counter_unit.sv */
// Daily bucket window counter: keeps up to 64 daily 64-bit event counts in a
// ring and answers range and window sums over them. One item at a time passes
// through a sequencer that drives a bucket memory with one read and one write
// port and one shared 64-bit adder, one bucket per cycle, so that memory sets
// the rate. An add zeroes a fresh bucket per skipped day, one for an empty
// ring and the whole ring once the gap reaches the window length, none when
// today is the newest day or earlier, then adds the count to the newest
// bucket. Range and window queries walk every held bucket, newest first. A
// clear empties the ring. The next item is taken while a result waits in the
// output register. No clearing pass follows reset. The user writes the window
// length register (byte address 0, APB port) only while idle; nothing enforces it.
module daily_bucket_window_counter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dbwc_in_if.sink                         i_in,
    dbwc_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dbwc_pkg::PADDR_W-1:0]    paddr,
    input  logic [dbwc_pkg::PDATA_W-1:0]    pwdata,
    output logic [dbwc_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    localparam int HW = dbwc_pkg::HELD_W;
    localparam int PW = dbwc_pkg::PDATA_W;

    logic [HW-1:0]               r_window;
    logic                        r_out_valid;
    logic [dbwc_pkg::SUM_W-1:0]  r_total;
    logic [HW-1:0]               r_held_out;

    logic                        start;
    logic                        ready;
    logic                        done;
    logic                        out_free;
    logic [HW-1:0]               held;
    logic [dbwc_pkg::SUM_W-1:0]  total;
    dbwc_pkg::t_dp_cmd           cmd;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= dbwc_pkg::WINDOW_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == dbwc_pkg::REG_WINDOW) begin
            r_window <= pwdata[HW-1:0];
        end
    end
    assign prdata = (paddr[2] == dbwc_pkg::REG_WINDOW) ? {{(PW-HW){1'b0}}, r_window} : '0;

    assign i_in.ready = ready;
    assign start      = i_in.valid && ready;
    assign out_free   = !r_out_valid || o_out.ready;

    dbwc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_op          (i_in.operation),
        .i_today       (i_in.today_day),
        .i_range_start (i_in.range_start_day),
        .i_range_end   (i_in.range_end_day),
        .i_window      (r_window),
        .i_out_free    (out_free),
        .o_ready       (ready),
        .o_done        (done),
        .o_held        (held),
        .o_cmd         (cmd)
    );

    dbwc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_count (i_in.count),
        .o_total (total)
    );

    // Result register: hold the item until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_total    <= total;
            r_held_out <= held;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.total        = r_total;
    assign o_out.buckets_held = r_held_out;

endmodule

/* hdl/dbwc_checker.sv */
// Port-level checks of the daily bucket window counter and their binding.
// Depends on dbwc_pkg and daily_bucket_window_counter_unit_macros.svh.
`include "daily_bucket_window_counter_unit_macros.svh"

module dbwc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [dbwc_pkg::SUM_W-1:0]    i_out_total,
    input logic [dbwc_pkg::HELD_W-1:0]   i_out_held
);

    // One item at a time: busy right after an item is taken
    `DBWC_ASSERT_NEXT(a_busy_after_take, i_in_valid && i_in_ready, !i_in_ready)

    // A stalled result holds
    `DBWC_ASSERT_NEXT(a_result_holds, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_total) && $stable(i_out_held))

    // The ring never holds more than its size
    `DBWC_ASSERT_NOW(a_held_bound, i_out_valid, int'(i_out_held) <= dbwc_pkg::DAYS_MAX)

    // An empty ring sums to zero
    `DBWC_ASSERT_NOW(a_empty_zero, i_out_valid && i_out_held == '0, i_out_total == '0)

endmodule

bind daily_bucket_window_counter_unit dbwc_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_total (o_out.total),
    .i_out_held  (o_out.buckets_held)
);
